// ===== rtl/rrtb_pkg.sv =====
// Package: widths, register indexes and stage types for the rounded-rect touch button.
`timescale 1ns / 1ps
`default_nettype none
package rrtb_pkg;

	localparam int COORD_BITS = 12;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int DIFF_BITS  = COORD_BITS + 2;
	localparam int SQ_BITS    = 2 * DIFF_BITS;
	localparam int R1SQ_BITS  = 2 * (RAD_BITS + 1);
	localparam int IDX_BITS   = 3;

	typedef enum logic [IDX_BITS-1:0] {
		REG_RECT_LEFT     = 3'd0,
		REG_RECT_TOP      = 3'd1,
		REG_RECT_RIGHT    = 3'd2,
		REG_RECT_BOTTOM   = 3'd3,
		REG_CORNER_RADIUS = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] rect_left;
		logic [COORD_BITS-1:0] rect_top;
		logic [COORD_BITS-1:0] rect_right;
		logic [COORD_BITS-1:0] rect_bottom;
		logic [RAD_BITS-1:0]   corner_radius;
	} cfg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  touching;
	} sample_t;

	typedef struct packed {
		logic                 touching;
		logic                 inbox;
		logic                 neg_xl;
		logic                 pos_xr;
		logic                 neg_yt;
		logic                 pos_yb;
		logic [SQ_BITS-1:0]   sq_xl;
		logic [SQ_BITS-1:0]   sq_xr;
		logic [SQ_BITS-1:0]   sq_yt;
		logic [SQ_BITS-1:0]   sq_yb;
		logic [R1SQ_BITS-1:0] r1sq;
	} geom_t;

endpackage
`default_nettype wire

// ===== rtl/rrtb_sample_if.sv =====
// Interface: touch sample channel.
`timescale 1ns / 1ps
`default_nettype none
interface rrtb_sample_if;
	logic                           valid;
	logic                           ready;
	logic [rrtb_pkg::COORD_BITS-1:0] touch_x;
	logic [rrtb_pkg::COORD_BITS-1:0] touch_y;
	logic [7:0]                     touch_pressure;

	modport source(output valid, output touch_x, output touch_y, output touch_pressure,
		input ready);
	modport sink(input valid, input touch_x, input touch_y, input touch_pressure,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/rrtb_result_if.sv =====
// Interface: button event channel.
`timescale 1ns / 1ps
`default_nettype none
interface rrtb_result_if;
	logic valid;
	logic ready;
	logic press_event;
	logic click_event;

	modport source(output valid, output press_event, output click_event, input ready);
	modport sink(input valid, input press_event, input click_event, output ready);
endinterface
`default_nettype wire

// ===== rtl/rrtb_cfg_regs.sv =====
// Configuration register file for the button geometry.
`timescale 1ns / 1ps
`default_nettype none
module rrtb_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rrtb_pkg::IDX_BITS-1:0]   cfg_index,
	input  wire logic [rrtb_pkg::COORD_BITS-1:0] cfg_data,
	output rrtb_pkg::cfg_t                       cfg
);

	rrtb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rect_left     <= '0;
			cfg_q.rect_top      <= '0;
			cfg_q.rect_right    <= '1;
			cfg_q.rect_bottom   <= '1;
			cfg_q.corner_radius <= '0;
		end else if (cfg_we) begin
			unique case (rrtb_pkg::reg_idx_t'(cfg_index))
				rrtb_pkg::REG_RECT_LEFT:     cfg_q.rect_left   <= cfg_data;
				rrtb_pkg::REG_RECT_TOP:      cfg_q.rect_top    <= cfg_data;
				rrtb_pkg::REG_RECT_RIGHT:    cfg_q.rect_right  <= cfg_data;
				rrtb_pkg::REG_RECT_BOTTOM:   cfg_q.rect_bottom <= cfg_data;
				rrtb_pkg::REG_CORNER_RADIUS: begin
					cfg_q.corner_radius <= cfg_data[rrtb_pkg::RAD_BITS-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/rrtb_geom.sv =====
// Geometry stage: box test, corner offsets and their squares.
`timescale 1ns / 1ps
`default_nettype none
module rrtb_geom (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rrtb_pkg::cfg_t    cfg,
	input  wire logic              valid_s1,
	input  wire rrtb_pkg::sample_t sample_s1,
	input  wire logic              ready_s3,
	output logic                   ready_s2,
	output logic                   valid_s2,
	output rrtb_pkg::geom_t        geom_s2
);

	localparam int CW = rrtb_pkg::COORD_BITS;
	localparam int DW = rrtb_pkg::DIFF_BITS;
	localparam int RW = rrtb_pkg::RAD_BITS;
	localparam int SW = rrtb_pkg::SQ_BITS;
	localparam int QW = rrtb_pkg::R1SQ_BITS;

	logic signed [DW-1:0] x_e, y_e, rad_e;
	logic signed [DW-1:0] lx, rx, ty, by;
	logic signed [DW-1:0] dxl, dxr, dyt, dyb;
	logic signed [rrtb_pkg::SQ_BITS-1:0] sq_xl, sq_xr, sq_yt, sq_yb;
	logic [RW:0] r1;
	rrtb_pkg::geom_t geom_d;
	logic v2_q;

	always_comb begin
		x_e   = $signed({{(DW-CW){1'b0}}, sample_s1.x});
		y_e   = $signed({{(DW-CW){1'b0}}, sample_s1.y});
		rad_e = $signed({{(DW-RW){1'b0}}, cfg.corner_radius});
		lx = $signed({{(DW-CW){1'b0}}, cfg.rect_left}) + rad_e;
		rx = $signed({{(DW-CW){1'b0}}, cfg.rect_right}) - rad_e;
		ty = $signed({{(DW-CW){1'b0}}, cfg.rect_top}) + rad_e;
		by = $signed({{(DW-CW){1'b0}}, cfg.rect_bottom}) - rad_e;
		dxl = x_e - lx;
		dxr = x_e - rx;
		dyt = y_e - ty;
		dyb = y_e - by;
		sq_xl = SW'(dxl) * SW'(dxl);
		sq_xr = SW'(dxr) * SW'(dxr);
		sq_yt = SW'(dyt) * SW'(dyt);
		sq_yb = SW'(dyb) * SW'(dyb);
		r1 = {1'b0, cfg.corner_radius} + {{RW{1'b0}}, 1'b1};

		geom_d.touching = sample_s1.touching;
		geom_d.inbox    = (sample_s1.x >= cfg.rect_left) && (sample_s1.x <= cfg.rect_right)
			&& (sample_s1.y >= cfg.rect_top) && (sample_s1.y <= cfg.rect_bottom);
		geom_d.neg_xl = dxl[DW-1];
		geom_d.pos_xr = !dxr[DW-1] && (dxr != '0);
		geom_d.neg_yt = dyt[DW-1];
		geom_d.pos_yb = !dyb[DW-1] && (dyb != '0);
		geom_d.sq_xl  = $unsigned(sq_xl);
		geom_d.sq_xr  = $unsigned(sq_xr);
		geom_d.sq_yt  = $unsigned(sq_yt);
		geom_d.sq_yb  = $unsigned(sq_yb);
		geom_d.r1sq   = QW'(r1) * QW'(r1);
	end

	assign ready_s2 = !v2_q || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (ready_s2) begin
			v2_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			geom_s2 <= geom_d;
		end
	end

	assign valid_s2 = v2_q;

endmodule
`default_nettype wire

// ===== rtl/rrtb_ctrl.sv =====
// Decision stage: corner distance test, press/click state and result register.
`timescale 1ns / 1ps
`default_nettype none
module rrtb_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s2,
	input  wire rrtb_pkg::geom_t geom_s2,
	output logic                 ready_s3,
	rrtb_result_if.source        result
);

	localparam int SW = rrtb_pkg::SQ_BITS;

	logic [SW:0] sum_tl, sum_tr, sum_bl, sum_br, lim;
	logic out_tl, out_tr, out_bl, out_br, in_shape;
	logic press_d, click_d;
	logic v3_q, was_touching_q, press_armed_q;
	logic press_s3, click_s3;

	always_comb begin
		sum_tl = {1'b0, geom_s2.sq_xl} + {1'b0, geom_s2.sq_yt};
		sum_tr = {1'b0, geom_s2.sq_xr} + {1'b0, geom_s2.sq_yt};
		sum_bl = {1'b0, geom_s2.sq_xl} + {1'b0, geom_s2.sq_yb};
		sum_br = {1'b0, geom_s2.sq_xr} + {1'b0, geom_s2.sq_yb};
		lim    = {{(SW+1-rrtb_pkg::R1SQ_BITS){1'b0}}, geom_s2.r1sq};
		out_tl = geom_s2.neg_xl && geom_s2.neg_yt && (sum_tl >= lim);
		out_tr = geom_s2.pos_xr && geom_s2.neg_yt && (sum_tr >= lim);
		out_bl = geom_s2.neg_xl && geom_s2.pos_yb && (sum_bl >= lim);
		out_br = geom_s2.pos_xr && geom_s2.pos_yb && (sum_br >= lim);
		in_shape = geom_s2.inbox && !(out_tl || out_tr || out_bl || out_br);
		press_d = geom_s2.touching && !was_touching_q && in_shape;
		click_d = !geom_s2.touching && press_armed_q && in_shape;
	end

	assign ready_s3 = !v3_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q           <= 1'b0;
			was_touching_q <= 1'b0;
			press_armed_q  <= 1'b0;
		end else if (ready_s3) begin
			v3_q <= valid_s2;
			if (valid_s2) begin
				was_touching_q <= geom_s2.touching;
				if (press_d) begin
					press_armed_q <= 1'b1;
				end else if (!geom_s2.touching) begin
					press_armed_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			press_s3 <= press_d;
			click_s3 <= click_d;
		end
	end

	assign result.valid       = v3_q;
	assign result.press_event = press_s3;
	assign result.click_event = click_s3;

endmodule
`default_nettype wire

// ===== rtl/rounded_rect_touch_button.sv =====
// Top level: rounded-rectangle touch button event detector.
// Each accepted touch sample yields exactly one result item carrying press_event and
// click_event, in sample order. The path is three register stages (sample register,
// geometry/squares register, result register), and one sample per cycle is accepted while
// the result side keeps up; throughput is set by the single-pass geometry stage, and a
// stalled result stalls the pipeline only once its free stages are used up. Configuration
// writes take effect on the next cycle and should be made while no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none
module rounded_rect_touch_button (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rrtb_pkg::IDX_BITS-1:0]   cfg_index,
	input  wire logic [rrtb_pkg::COORD_BITS-1:0] cfg_data,
	rrtb_sample_if.sink                          sample,
	rrtb_result_if.source                        result
);

	rrtb_pkg::cfg_t    cfg;
	rrtb_pkg::sample_t sample_s1;
	rrtb_pkg::geom_t   geom_s2;
	logic v1_q, valid_s2, ready_s1, ready_s2, ready_s3;

	rrtb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign ready_s1     = !v1_q || ready_s2;
	assign sample.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (ready_s1) begin
			v1_q <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && sample.valid) begin
			sample_s1.x        <= sample.touch_x;
			sample_s1.y        <= sample.touch_y;
			sample_s1.touching <= (sample.touch_pressure != 8'd0);
		end
	end

	rrtb_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (v1_q),
		.sample_s1 (sample_s1),
		.ready_s3  (ready_s3),
		.ready_s2  (ready_s2),
		.valid_s2  (valid_s2),
		.geom_s2   (geom_s2)
	);

	rrtb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.geom_s2  (geom_s2),
		.ready_s3 (ready_s3),
		.result   (result)
	);

endmodule
`default_nettype wire

// ===== rtl/rrtb_checker.sv =====
// Port checker for the touch button and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rrtb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	input wire logic sample_ready,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic press_event,
	input wire logic click_event
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(press_event && click_event))
		else $error("press and click in one item");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(press_event) && $stable(click_event))
		else $error("result payload changed while stalled");

	a_ready_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !$past(sample_valid) && $past(arst_n) |-> sample_ready)
		else $error("sample not accepted with an empty pipeline");

endmodule

bind rounded_rect_touch_button rrtb_checker u_rrtb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.press_event  (result.press_event),
	.click_event  (result.click_event)
);
`default_nettype wire
